// ----- rtl/multichannel_biquad_filter_macros.svh -----
// ----------------------------------------------------------------------------
// multichannel biquad filter assertion macros
// shared concurrent assertion forms, clocked on clk_i and gated by rst_ni
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_BIQUAD_FILTER_MACROS_SVH
`define MULTICHANNEL_BIQUAD_FILTER_MACROS_SVH

// property must hold at every edge out of reset
`define MBQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen out of reset
`define MBQ_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- rtl/mbq_pkg.sv -----
// ----------------------------------------------------------------------------
// mbq_pkg
// shared constants and types of the multichannel biquad filter
// ----------------------------------------------------------------------------
package mbq_pkg;

  localparam int unsigned DEF_CHANNELS    = 8;
  localparam int unsigned DEF_SAMPLE_BITS = 16;

  localparam int unsigned CHAN_W     = 3;   // channel tag width
  localparam int unsigned COEF_W     = 20;  // signed q4.16
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned NUM_COEFS  = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned MAX_ADDR_W = 6;   // up to 64 channels

  // configuration register index
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FF0 = 3'd0,
    REG_FF1 = 3'd1,
    REG_FF2 = 3'd2,
    REG_FB1 = 3'd3,
    REG_FB2 = 3'd4
  } cfg_reg_e;

  // source of the history word returned by the memory
  typedef enum logic [1:0] {
    RD_MEM,
    RD_ZERO,
    RD_FWD
  } rd_sel_e;

  // history memory command
  typedef struct packed {
    logic                  rd_en;
    logic [MAX_ADDR_W-1:0] rd_addr;
    logic                  wr_en;
    logic [MAX_ADDR_W-1:0] wr_addr;
  } mem_cmd_t;

endpackage

// ----- rtl/mbq_ifs.sv -----
// ----------------------------------------------------------------------------
// mbq stream interfaces
// valid/ready channels for input samples and filtered results
// ----------------------------------------------------------------------------
interface mbq_in_if #(
  parameter int unsigned SAMPLE_BITS = mbq_pkg::DEF_SAMPLE_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic [mbq_pkg::CHAN_W-1:0]    channel;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output channel, output sample_in, input ready);
  modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

interface mbq_out_if #(
  parameter int unsigned SAMPLE_BITS = mbq_pkg::DEF_SAMPLE_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic [mbq_pkg::CHAN_W-1:0]    channel_out;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;

  modport source (output valid, output channel_out, output sample_out, output clipped,
                  input ready);
  modport sink   (input valid, input channel_out, input sample_out, input clipped,
                  output ready);
endinterface

// ----- rtl/multichannel_biquad_filter.sv -----
// ----------------------------------------------------------------------------
// multichannel_biquad_filter
// direct form 1 biquad over interleaved channels, history kept in memory
// ----------------------------------------------------------------------------
// Each input item is a signed sample tagged with a channel; each yields one
// result item y = ff0*x + ff1*x1 + ff2*x2 - fb1*y1 - fb2*y2, floored by 16
// fraction bits and saturated, with clipped set when saturation hit. The
// block accepts one item per cycle while the output is not stalled and
// consecutive items name different channels. An item whose channel equals
// that of the item accepted just before it is held back: the history
// read-modify-write loop (memory read, five multipliers, sum and saturate,
// write back) spans two stages, and the newer item can only read once the
// older one writes. An accepted item passes stage 1, stage 2 and the result
// register on its way out. Channels at or above CHANNELS pass through with
// sample_out zero and no history change. Histories read as zero after reset
// through per-channel valid bits, so no clearing pass is needed. Coefficients
// are written through the plain write port; the user must keep such writes to
// times when no item is in flight, as the block does not enforce it. The
// interfaces must be built with the same SAMPLE_BITS as this block.
// ----------------------------------------------------------------------------
`include "multichannel_biquad_filter_macros.svh"

module multichannel_biquad_filter #(
  parameter int unsigned CHANNELS    = mbq_pkg::DEF_CHANNELS,
  parameter int unsigned SAMPLE_BITS = mbq_pkg::DEF_SAMPLE_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mbq_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mbq_pkg::COEF_W-1:0]      cfg_data_i,
  mbq_in_if.sink                          in_i,
  mbq_out_if.source                       out_o
);
  import mbq_pkg::*;

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned HistW = 4 * SB;
  localparam int unsigned ProdW = COEF_W + SB;
  localparam int unsigned AccW  = ProdW + 3;

  localparam logic [6:0] ChanLimit = 7'(CHANNELS);

  // saturation bounds at accumulator and output width
  localparam logic signed [AccW-1:0] SatHi = {{(AccW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [AccW-1:0] SatLo = {{(AccW-SB+1){1'b1}}, {(SB-1){1'b0}}};
  localparam logic signed [SB-1:0]   OutHi = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0]   OutLo = {1'b1, {(SB-1){1'b0}}};

  // coefficient registers
  logic signed [COEF_W-1:0] ff0_q, ff1_q, ff2_q, fb1_q, fb2_q;

  // stage 1: history read in flight
  logic                 s1_v_q;
  logic [CHAN_W-1:0]    s1_ch_q;
  logic                 s1_hit_q;
  logic signed [SB-1:0] s1_x_q;

  // stage 2: products registered
  logic                    s2_v_q;
  logic [CHAN_W-1:0]       s2_ch_q;
  logic                    s2_hit_q;
  logic signed [SB-1:0]    s2_x_q, s2_x1_q, s2_y1_q;
  logic signed [ProdW-1:0] s2_p0_q, s2_p1_q, s2_p2_q, s2_p3_q, s2_p4_q;

  // result register
  logic                 out_v_q;
  logic [CHAN_W-1:0]    out_ch_q;
  logic signed [SB-1:0] out_smp_q;
  logic                 out_clip_q;

  logic [HistW-1:0]     hist;
  logic signed [SB-1:0] h_x1, h_x2, h_y1, h_y2;
  logic [HistW-1:0]     wr_data;
  mem_cmd_t             mem_cmd;

  logic in_hit, in_acc, hazard;
  logic out_adv, s2_adv, s1_adv;

  logic signed [AccW-1:0] acc, acc_fl;
  logic signed [SB-1:0]   y_sat;
  logic                   y_clip;

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ff0_q <= '0;
      ff1_q <= '0;
      ff2_q <= '0;
      fb1_q <= '0;
      fb2_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FF0: ff0_q <= cfg_data_i;
        REG_FF1: ff1_q <= cfg_data_i;
        REG_FF2: ff2_q <= cfg_data_i;
        REG_FB1: fb1_q <= cfg_data_i;
        REG_FB2: fb2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline advance, bubbles collapse toward the result register
  assign out_adv = !out_v_q || out_o.ready;
  assign s2_adv  = !s2_v_q || out_adv;
  assign s1_adv  = !s1_v_q || s2_adv;

  assign in_hit = {4'b0, in_i.channel} < ChanLimit;

  // interlock: an older item of the same channel that has not written yet
  assign hazard = in_hit &&
                  ((s1_v_q && s1_hit_q && (s1_ch_q == in_i.channel)) ||
                   (s2_v_q && s2_hit_q && (s2_ch_q == in_i.channel) && !s2_adv));

  assign in_i.ready = s1_adv && !hazard;
  assign in_acc     = in_i.valid && in_i.ready;

  // history word layout: {y2, y1, x2, x1}
  assign h_x1 = hist[SB-1:0];
  assign h_x2 = hist[2*SB-1:SB];
  assign h_y1 = hist[3*SB-1:2*SB];
  assign h_y2 = hist[4*SB-1:3*SB];

  // shifted history: y1 -> y2, new y -> y1, x1 -> x2, x -> x1
  assign wr_data = {s2_y1_q, y_sat, s2_x1_q, s2_x_q};

  always_comb begin
    mem_cmd         = '0;
    mem_cmd.rd_en   = in_acc && in_hit;
    mem_cmd.rd_addr = MAX_ADDR_W'(in_i.channel);
    mem_cmd.wr_en   = s2_v_q && s2_hit_q && s2_adv;
    mem_cmd.wr_addr = MAX_ADDR_W'(s2_ch_q);
  end

  mbq_hist_mem #(
    .CHANNELS (CHANNELS),
    .HIST_W   (HistW)
  ) u_hist_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (mem_cmd),
    .wr_data_i (wr_data),
    .rd_data_o (hist)
  );

  // stage 1 load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_adv) begin
      s1_v_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ch_q  <= in_i.channel;
      s1_hit_q <= in_hit;
      s1_x_q   <= in_i.sample_in;
    end
  end

  // stage 2: five products from the history just read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_adv) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && s1_v_q) begin
      s2_ch_q  <= s1_ch_q;
      s2_hit_q <= s1_hit_q;
      s2_x_q   <= s1_x_q;
      s2_x1_q  <= h_x1;
      s2_y1_q  <= h_y1;
      s2_p0_q  <= ProdW'(ff0_q * s1_x_q);
      s2_p1_q  <= ProdW'(ff1_q * h_x1);
      s2_p2_q  <= ProdW'(ff2_q * h_x2);
      s2_p3_q  <= ProdW'(fb1_q * h_y1);
      s2_p4_q  <= ProdW'(fb2_q * h_y2);
    end
  end

  // sum, floor by the fraction bits, saturate
  always_comb begin
    acc = AccW'(s2_p0_q) + AccW'(s2_p1_q) + AccW'(s2_p2_q)
        - AccW'(s2_p3_q) - AccW'(s2_p4_q);
    acc_fl = acc >>> FRAC_BITS;
    if (acc_fl > SatHi) begin
      y_sat  = OutHi;
      y_clip = 1'b1;
    end else if (acc_fl < SatLo) begin
      y_sat  = OutLo;
      y_clip = 1'b1;
    end else begin
      y_sat  = acc_fl[SB-1:0];
      y_clip = 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_adv) begin
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s2_v_q) begin
      out_ch_q   <= s2_ch_q;
      out_smp_q  <= s2_hit_q ? y_sat : '0;
      out_clip_q <= s2_hit_q && y_clip;
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.channel_out = out_ch_q;
  assign out_o.sample_out  = out_smp_q;
  assign out_o.clipped     = out_clip_q;

  // the item waiting on its read must never see its channel written behind it
  `MBQ_ASSERT_NEVER(a_stale_hist, mem_cmd.wr_en && s1_v_q && s1_hit_q && (s1_ch_q == s2_ch_q), "stale history read")
  // an accepted item occupies stage 1 next cycle
  `MBQ_ASSERT(a_s1_load, in_acc |=> (s1_v_q && (s1_ch_q == $past(in_i.channel))), "item lost at stage 1")
  // a clipped result sits at one of the bounds
  `MBQ_ASSERT(a_clip_bound, (out_v_q && out_clip_q) |-> ((out_smp_q == OutHi) || (out_smp_q == OutLo)), "clip flag off bound")

endmodule

// ----- rtl/mbq_hist_mem.sv -----
// ----------------------------------------------------------------------------
// mbq_hist_mem
// per-channel history memory, registered read, valid bits, write-first bypass
// ----------------------------------------------------------------------------
module mbq_hist_mem #(
  parameter int unsigned CHANNELS = mbq_pkg::DEF_CHANNELS,
  parameter int unsigned HIST_W   = 4 * mbq_pkg::DEF_SAMPLE_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mbq_pkg::mem_cmd_t cmd_i,
  input  logic [HIST_W-1:0] wr_data_i,
  output logic [HIST_W-1:0] rd_data_o
);
  import mbq_pkg::*;

  localparam int unsigned AddrW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [HIST_W-1:0]   mem_q [CHANNELS];
  logic [HIST_W-1:0]   rd_q;
  logic [HIST_W-1:0]   fwd_q;
  logic [CHANNELS-1:0] vld_q;
  rd_sel_e             sel_q;
  rd_sel_e             sel_d;
  logic [AddrW-1:0]    rd_addr;
  logic [AddrW-1:0]    wr_addr;

  assign rd_addr = cmd_i.rd_addr[AddrW-1:0];
  assign wr_addr = cmd_i.wr_addr[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wr_data_i;
    end
    if (cmd_i.rd_en) begin
      rd_q  <= mem_q[rd_addr];
      fwd_q <= wr_data_i;
    end
  end

  // same-cycle write to the read entry wins, unwritten entries read zero
  always_comb begin
    sel_d = sel_q;
    if (cmd_i.rd_en) begin
      if (cmd_i.wr_en && (wr_addr == rd_addr)) begin
        sel_d = RD_FWD;
      end else if (!vld_q[rd_addr]) begin
        sel_d = RD_ZERO;
      end else begin
        sel_d = RD_MEM;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      sel_q <= RD_ZERO;
    end else begin
      sel_q <= sel_d;
      if (cmd_i.wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_comb begin
    case (sel_q)
      RD_MEM:  rd_data_o = rd_q;
      RD_FWD:  rd_data_o = fwd_q;
      default: rd_data_o = '0;
    endcase
  end

endmodule
